// File: src/stt_pkg.sv
// ============================================================================
// stt_pkg
// Shared types, token kind codes and byte classification for the source
// text tokenizer.
// ============================================================================
package stt_pkg;

    localparam int POSITION_BITS_DEFAULT  = 16;
    localparam int MAX_RUN_LENGTH_DEFAULT = 255;

    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 5;
    localparam int START_W  = 16;
    localparam int LENGTH_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_DQUOTE     = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_SQUOTE     = 8'h27;
    localparam logic [CHAR_W-1:0] CHAR_BAR        = 8'h7C;

    typedef enum logic [KIND_W-1:0] {
        KIND_NUMBER   = 5'd0,
        KIND_IDENT    = 5'd1,
        KIND_LPAREN   = 5'd2,
        KIND_RPAREN   = 5'd3,
        KIND_LBRACKET = 5'd4,
        KIND_RBRACKET = 5'd5,
        KIND_LBRACE   = 5'd6,
        KIND_RBRACE   = 5'd7,
        KIND_LESS     = 5'd8,
        KIND_GREATER  = 5'd9,
        KIND_EQUAL    = 5'd10,
        KIND_PLUS     = 5'd11,
        KIND_MINUS    = 5'd12,
        KIND_STAR     = 5'd13,
        KIND_SLASH    = 5'd14,
        KIND_HASH     = 5'd15,
        KIND_DOT      = 5'd16,
        KIND_COMMA    = 5'd17,
        KIND_COLON    = 5'd18,
        KIND_SEMI     = 5'd19,
        KIND_SQUOTE   = 5'd20,
        KIND_DQUOTE   = 5'd21,
        KIND_COMMENT  = 5'd22,
        KIND_BAR      = 5'd23,
        KIND_END      = 5'd24,
        KIND_ERROR    = 5'd25
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_IDENT  = 2'd2
    } mode_t;

    typedef struct packed {
        kind_t                 kind;
        logic [START_W-1:0]    start;
        logic [LENGTH_W-1:0]   length;
        logic                  saturated;
        logic                  last;
    } token_t;

    // Up to two tokens leave the lexer for each byte it processes.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } punct_t;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        logic r;
        r = (c == CHAR_SPACE) || (c inside {[8'd9:8'd13]});
        return r;
    endfunction

    function automatic logic is_dig(input logic [CHAR_W-1:0] c);
        logic r;
        r = c inside {[8'h30:8'h39]};
        return r;
    endfunction

    function automatic logic is_word(input logic [CHAR_W-1:0] c);
        logic r;
        r = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
            || (c == CHAR_UNDERSCORE);
        return r;
    endfunction

    function automatic punct_t punct_kind(input logic [CHAR_W-1:0] c);
        punct_t r;
        r.hit = 1'b1;
        case (c)
            8'h28:       r.kind = KIND_LPAREN;
            8'h29:       r.kind = KIND_RPAREN;
            8'h5B:       r.kind = KIND_LBRACKET;
            8'h5D:       r.kind = KIND_RBRACKET;
            8'h7B:       r.kind = KIND_LBRACE;
            8'h7D:       r.kind = KIND_RBRACE;
            8'h3C:       r.kind = KIND_LESS;
            8'h3E:       r.kind = KIND_GREATER;
            8'h3D:       r.kind = KIND_EQUAL;
            8'h2B:       r.kind = KIND_PLUS;
            8'h2D:       r.kind = KIND_MINUS;
            8'h2A:       r.kind = KIND_STAR;
            8'h2F:       r.kind = KIND_SLASH;
            8'h23:       r.kind = KIND_HASH;
            8'h2E:       r.kind = KIND_DOT;
            8'h2C:       r.kind = KIND_COMMA;
            8'h3A:       r.kind = KIND_COLON;
            8'h3B:       r.kind = KIND_SEMI;
            CHAR_SQUOTE: r.kind = KIND_SQUOTE;
            CHAR_DQUOTE: r.kind = KIND_DQUOTE;
            CHAR_BAR:    r.kind = KIND_BAR;
            default:
            begin
                r.hit  = 1'b0;
                r.kind = KIND_ERROR;
            end
        endcase
        return r;
    endfunction

endpackage

// File: src/stt_lexer.sv
// ============================================================================
// stt_lexer
// Input word register, run state and token generation for one byte a cycle while space_ok is high.
// ============================================================================
module stt_lexer #(
    parameter int POSITION_BITS  = stt_pkg::POSITION_BITS_DEFAULT,
    parameter int MAX_RUN_LENGTH = stt_pkg::MAX_RUN_LENGTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [stt_pkg::CHAR_W-1:0]  char_code,
    input  logic                        space_ok,
    output stt_pkg::push_t              push
);
    import stt_pkg::*;

    localparam int COUNT_W = $clog2(MAX_RUN_LENGTH + 1);
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_RUN_LENGTH);

    logic                      hold_valid_reg, hold_valid_next;
    logic [CHAR_W-1:0]         hold_char_reg;
    mode_t                     mode_reg, mode_next;
    logic [POSITION_BITS-1:0]  start_reg, start_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      clipped_reg, clipped_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;

    logic       fire;
    logic       run_open;
    logic       cont;
    token_t     run_tok;
    token_t     byte_tok;
    logic       byte_emit;
    punct_t     pk;
    logic [CHAR_W-1:0] c;

    assign c        = hold_char_reg;
    assign fire     = hold_valid_reg && space_ok;
    assign in_ready = !hold_valid_reg || space_ok;
    assign hold_valid_next = in_ready ? in_valid : hold_valid_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_char_reg <= char_code;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_NUMBER:
            begin
                run_open = 1'b1;
                cont     = is_dig(c);
            end
            MODE_IDENT:
            begin
                run_open = 1'b1;
                cont     = is_word(c);
            end
            default:
            begin
                run_open = 1'b0;
                cont     = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pk = punct_kind(c);

        mode_next    = mode_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        clipped_next = clipped_reg;
        pos_next     = pos_reg;

        run_tok.kind      = (mode_reg == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
        run_tok.start     = START_W'(start_reg);
        run_tok.length    = LENGTH_W'(count_reg);
        run_tok.saturated = clipped_reg;
        run_tok.last      = 1'b0;

        byte_emit          = 1'b0;
        byte_tok.kind      = KIND_ERROR;
        byte_tok.start     = START_W'(pos_reg);
        byte_tok.length    = LENGTH_W'(1);
        byte_tok.saturated = 1'b0;
        byte_tok.last      = 1'b1;

        if (run_open && cont)
        begin
            if (count_reg < MAX_COUNT)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                clipped_next = 1'b1;
            end
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            mode_next    = MODE_NONE;
            count_next   = '0;
            clipped_next = 1'b0;
            if (c == CHAR_NUL)
            begin
                byte_emit       = 1'b1;
                byte_tok.kind   = KIND_END;
                byte_tok.length = '0;
                start_next      = '0;
                pos_next        = '0;
            end
            else
            begin
                if (is_ws(c))
                begin
                    byte_emit = 1'b0;
                end
                else if (pk.hit)
                begin
                    byte_emit     = 1'b1;
                    byte_tok.kind = pk.kind;
                end
                else if (is_dig(c) || is_word(c))
                begin
                    mode_next  = is_dig(c) ? MODE_NUMBER : MODE_IDENT;
                    start_next = pos_reg;
                    count_next = COUNT_W'(1);
                end
                else
                begin
                    byte_emit = 1'b1;
                end
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Pack the run token ahead of the byte's own token; the final one is last.
    always_comb
    begin
        push.count  = 2'd0;
        push.first  = byte_tok;
        push.second = byte_tok;
        if (fire && run_open && !cont)
        begin
            push.first      = run_tok;
            push.first.last = !byte_emit;
            push.count      = byte_emit ? 2'd2 : 2'd1;
        end
        else if (fire && byte_emit)
        begin
            push.count = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            mode_reg       <= MODE_NONE;
            start_reg      <= '0;
            count_reg      <= '0;
            clipped_reg    <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (fire)
            begin
                mode_reg    <= mode_next;
                start_reg   <= start_next;
                count_reg   <= count_next;
                clipped_reg <= clipped_next;
                pos_reg     <= pos_next;
            end
        end
    end

endmodule

// File: src/stt_token_fifo.sv
// ============================================================================
// stt_token_fifo
// Four-entry token queue that takes up to two tokens and gives one a cycle while out_ready is high.
// ============================================================================
module stt_token_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  stt_pkg::push_t  push,
    output logic            space_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output stt_pkg::token_t head
);
    import stt_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    token_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign out_valid    = (count_reg != '0);
    assign pop          = out_valid && out_ready;
    assign head         = mem[rd_ptr_reg];
    // Room for the worst case of two tokens from one word.
    assign space_ok     = (count_reg <= (PTR_W + 1)'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign count_next   = count_reg + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/source_text_tokenizer.sv
// ============================================================================
// source_text_tokenizer
// Streaming tokenizer: one source byte in, number, identifier, punctuation,
// error and end tokens out.
// ============================================================================
// Usage:
//   The input channel takes one byte word (char_code) per cycle under
//   in_valid/in_ready. A zero byte ends the text, emits an End token and
//   restarts positions at zero. The output channel gives one token word per
//   cycle under out_valid/out_ready; last_of_step marks the final token of
//   the byte that caused it.
//   Path: a byte is held in the input register, where it is classified;
//   its tokens are written into a four-entry token queue once it has
//   room for two, and the first one is on the output from then on.
//   Throughput: one byte per cycle while the queue has room for two tokens.
//   A byte that closes a run and is itself punctuation yields two tokens,
//   and the single-word output port then sets the pace.
//   When the receiver stalls, the queue fills; once fewer than two entries
//   are free the byte in the input register waits and in_ready drops.
//   Nothing is lost or reordered.
//   Reset clears the queue, the run state and the byte position.
// ============================================================================
module source_text_tokenizer #(
    parameter int POSITION_BITS  = stt_pkg::POSITION_BITS_DEFAULT,
    parameter int MAX_RUN_LENGTH = stt_pkg::MAX_RUN_LENGTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [stt_pkg::CHAR_W-1:0]    char_code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [stt_pkg::KIND_W-1:0]    token_kind,
    output logic [stt_pkg::START_W-1:0]   token_start,
    output logic [stt_pkg::LENGTH_W-1:0]  token_length,
    output logic                          length_saturated,
    output logic                          last_of_step
);
    import stt_pkg::*;

    push_t  push;
    logic   space_ok;
    token_t head;

    stt_lexer #(
        .POSITION_BITS  (POSITION_BITS),
        .MAX_RUN_LENGTH (MAX_RUN_LENGTH)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .space_ok  (space_ok),
        .push      (push)
    );

    stt_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign token_kind       = head.kind;
    assign token_start      = head.start;
    assign token_length     = head.length;
    assign length_saturated = head.saturated;
    assign last_of_step     = head.last;

endmodule
